// File: rtl/fir_equalizer_filter_defines.svh
// Assertion macros used by the checker file of the FIR equalizer filter.
// No dependencies.
`ifndef FIR_EQUALIZER_FILTER_DEFINES_SVH
`define FIR_EQUALIZER_FILTER_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define FIREQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define FIREQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/fireq_pkg.sv
// Shared widths, opcodes and arithmetic constants of the FIR equalizer filter.
// No dependencies; used by the top level, its checker and the testbench.
package fireq_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int COEF_W            = 18;
   localparam int COEF_INDEX_W      = 6;
   localparam int HALF_SPAN_DEFAULT = 16;

   // sample operand is consumed one digit per cycle, low digit first
   localparam int DIGIT_W     = 8;
   localparam int NUM_DIGITS  = SAMPLE_W / DIGIT_W;
   localparam int DIGIT_CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam int ROUND_SHIFT = 15;
   localparam int ROUND_BIAS  = 2 ** (ROUND_SHIFT - 1);
   localparam int SAT_MAX     = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAT_MIN     = -(2 ** (SAMPLE_W - 1));

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

endpackage

// File: rtl/fir_equalizer_filter.sv
// Direct-form FIR filter with a digit-serial multiply-accumulate datapath.
// Depends on fireq_pkg.
//
// Usage:
//  - Request channel (req_*): req_opcode selects filter (sample in req_sample_in)
//    or coefficient load (req_coef_index, req_coef_value). A transaction completes
//    at a clock edge with req_valid high and req_stall low.
//  - Response channel (rsp_*): one rsp_sample_out per filter transaction, rounded
//    to nearest (ties up) and saturated to 16 bits. Loads give no response;
//    an index at or beyond the tap count (2*HALF_SPAN+1) is dropped.
//  - Throughput: a load completes on acceptance and leaves the request channel
//    unstalled. A filter transaction (33 taps by default) stalls it through the
//    fetch, prime, MAC and round steps: one 8-bit digit of the sample times the
//    18-bit coefficient per cycle, two digits per tap.
//  - The output register lets a new request be accepted while a result waits.
//    If rsp_stall holds the previous result, the round step waits, and the
//    request side stays stalled until the result can be written.
//  - Reset (synchronous, active high) empties the delay line (fill count) and
//    marks every coefficient invalid, so both read as zero until written.
module fir_equalizer_filter #(
   parameter int HALF_SPAN = fireq_pkg::HALF_SPAN_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_opcode,
   input  logic signed [fireq_pkg::SAMPLE_W-1:0]      req_sample_in,
   input  logic        [fireq_pkg::COEF_INDEX_W-1:0]  req_coef_index,
   input  logic signed [fireq_pkg::COEF_W-1:0]        req_coef_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [fireq_pkg::SAMPLE_W-1:0]      rsp_sample_out
);

   localparam int TAPS   = 2 * HALF_SPAN + 1;
   localparam int IDX_W  = $clog2(TAPS);
   localparam int EXT_W  = (IDX_W > fireq_pkg::COEF_INDEX_W) ? IDX_W : fireq_pkg::COEF_INDEX_W;
   localparam int ACC_W  = fireq_pkg::SAMPLE_W + fireq_pkg::COEF_W + IDX_W;
   localparam int PART_W = fireq_pkg::DIGIT_W + 1 + fireq_pkg::COEF_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   localparam logic [fireq_pkg::DIGIT_CNT_W-1:0] LAST_DIGIT =
      fireq_pkg::DIGIT_CNT_W'(fireq_pkg::NUM_DIGITS - 1);
   localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(TAPS - 1);

   logic [2:0]                              state_ff, state_in;
   logic [IDX_W-1:0]                        hp_ff, hp_in;
   logic [IDX_W-1:0]                        fill_ff, fill_in;
   logic [IDX_W-1:0]                        rd_tap_ff, rd_tap_in;
   logic [IDX_W-1:0]                        mac_tap_ff, mac_tap_in;
   logic [fireq_pkg::DIGIT_CNT_W-1:0]       digit_ff, digit_in;
   logic [TAPS-1:0]                         coef_valid_ff, coef_valid_in;
   logic signed [ACC_W-1:0]                 acc_ff, acc_in;
   logic signed [fireq_pkg::SAMPLE_W-1:0]   samp_sh_ff, samp_sh_in;
   logic signed [fireq_pkg::COEF_W-1:0]     coef_op_ff, coef_op_in;
   logic                                    samp_ok_ff, samp_ok_in;
   logic                                    coef_ok_ff, coef_ok_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [fireq_pkg::SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic signed [fireq_pkg::SAMPLE_W-1:0]   samp_mem_ff [TAPS];
   logic signed [fireq_pkg::COEF_W-1:0]     coef_mem_ff [TAPS];
   logic signed [fireq_pkg::SAMPLE_W-1:0]   samp_rd_ff;
   logic signed [fireq_pkg::COEF_W-1:0]     coef_rd_ff;

   logic                                    accept;
   logic                                    samp_wr;
   logic                                    coef_wr;
   logic [EXT_W-1:0]                        idx_ext;
   logic [IDX_W-1:0]                        coef_waddr;
   logic [IDX_W-1:0]                        samp_raddr;
   logic [IDX_W:0]                          raddr_wrap;
   logic [IDX_W-1:0]                        rd_tap_inc;
   logic [fireq_pkg::DIGIT_W-1:0]           digit;
   logic signed [fireq_pkg::DIGIT_W:0]      digit_s;
   logic signed [PART_W-1:0]                partial;
   logic signed [ACC_W-1:0]                 part_ext;
   logic signed [ACC_W-1:0]                 part_shift;
   logic signed [ACC_W-1:0]                 rnd_sum;
   logic signed [ACC_W-1:0]                 rnd_q;
   logic signed [fireq_pkg::SAMPLE_W-1:0]   sat_val;
   logic                                    out_free;

   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid && !req_stall;
   assign samp_wr        = accept && (req_opcode == fireq_pkg::OP_FILTER);
   assign idx_ext        = EXT_W'(req_coef_index);
   assign coef_waddr     = idx_ext[IDX_W-1:0];
   assign coef_wr        = accept && (req_opcode == fireq_pkg::OP_LOAD) &&
                           (idx_ext < EXT_W'(TAPS));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   // delay line is circular: tap j sits j entries behind the head
   assign raddr_wrap = {1'b0, hp_ff} + (IDX_W + 1)'(TAPS) - {1'b0, rd_tap_ff};
   assign samp_raddr = (hp_ff >= rd_tap_ff) ? (hp_ff - rd_tap_ff) : raddr_wrap[IDX_W-1:0];
   assign rd_tap_inc = (rd_tap_ff == LAST_TAP) ? '0 : rd_tap_ff + 1'b1;

   // top digit carries the sign, lower digits are unsigned
   assign digit      = samp_sh_ff[fireq_pkg::DIGIT_W-1:0];
   assign digit_s    = {(digit_ff == LAST_DIGIT) & digit[fireq_pkg::DIGIT_W-1], digit};
   assign partial    = digit_s * coef_op_ff;
   assign part_ext   = ACC_W'(partial);
   assign part_shift = part_ext <<< (fireq_pkg::DIGIT_W * int'(digit_ff));

   assign rnd_sum = acc_ff + ACC_W'(fireq_pkg::ROUND_BIAS);
   assign rnd_q   = rnd_sum >>> fireq_pkg::ROUND_SHIFT;

   always_comb begin
      if (rnd_q > ACC_W'(fireq_pkg::SAT_MAX)) begin
         sat_val = fireq_pkg::SAMPLE_W'(fireq_pkg::SAT_MAX);
      end else if (rnd_q < ACC_W'(fireq_pkg::SAT_MIN)) begin
         sat_val = fireq_pkg::SAMPLE_W'(fireq_pkg::SAT_MIN);
      end else begin
         sat_val = rnd_q[fireq_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      hp_in         = hp_ff;
      fill_in       = fill_ff;
      rd_tap_in     = rd_tap_ff;
      mac_tap_in    = mac_tap_ff;
      digit_in      = digit_ff;
      coef_valid_in = coef_valid_ff;
      acc_in        = acc_ff;
      samp_sh_in    = samp_sh_ff;
      coef_op_in    = coef_op_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      samp_ok_in    = (rd_tap_ff < fill_ff);
      coef_ok_in    = coef_valid_ff[rd_tap_ff];

      if (coef_wr) begin
         coef_valid_in[coef_waddr] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (samp_wr) begin
               rd_tap_in = '0;
               if (fill_ff != LAST_TAP + 1'b1 || fill_ff == '0) begin
                  fill_in = (fill_ff == IDX_W'(TAPS)) ? fill_ff : fill_ff + 1'b1;
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            samp_sh_in = samp_ok_ff ? samp_rd_ff : '0;
            coef_op_in = coef_ok_ff ? coef_rd_ff : '0;
            acc_in     = '0;
            digit_in   = '0;
            mac_tap_in = '0;
            rd_tap_in  = rd_tap_inc;
            state_in   = ST_MAC;
         end
         ST_MAC: begin
            acc_in = acc_ff + part_shift;
            if (digit_ff != LAST_DIGIT) begin
               digit_in   = digit_ff + 1'b1;
               samp_sh_in = samp_sh_ff >>> fireq_pkg::DIGIT_W;
            end else begin
               digit_in = '0;
               if (mac_tap_ff == LAST_TAP) begin
                  state_in = ST_ROUND;
               end else begin
                  // load next tap's operands, prefetched during this tap
                  samp_sh_in = samp_ok_ff ? samp_rd_ff : '0;
                  coef_op_in = coef_ok_ff ? coef_rd_ff : '0;
                  mac_tap_in = mac_tap_ff + 1'b1;
                  rd_tap_in  = rd_tap_inc;
               end
            end
         end
         ST_ROUND: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_data_in  = sat_val;
               rsp_valid_in = 1'b1;
               hp_in        = (hp_ff == LAST_TAP) ? '0 : hp_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hp_ff         <= '0;
         fill_ff       <= '0;
         rd_tap_ff     <= '0;
         mac_tap_ff    <= '0;
         digit_ff      <= '0;
         coef_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hp_ff         <= hp_in;
         fill_ff       <= fill_in;
         rd_tap_ff     <= rd_tap_in;
         mac_tap_ff    <= mac_tap_in;
         digit_ff      <= digit_in;
         coef_valid_ff <= coef_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      samp_sh_ff  <= samp_sh_in;
      coef_op_ff  <= coef_op_in;
      samp_ok_ff  <= samp_ok_in;
      coef_ok_ff  <= coef_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (samp_wr) begin
         samp_mem_ff[hp_ff] <= req_sample_in;
      end
      samp_rd_ff <= samp_mem_ff[samp_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem_ff[coef_waddr] <= req_coef_value;
      end
      coef_rd_ff <= coef_mem_ff[rd_tap_ff];
   end

endmodule

// File: rtl/fireq_checker.sv
// Port-level checker for the FIR equalizer filter, bound to the top level.
// Depends on fireq_pkg and fir_equalizer_filter_defines.svh.
`include "fir_equalizer_filter_defines.svh"

module fireq_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_opcode,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [fireq_pkg::SAMPLE_W-1:0]  rsp_sample_out
);

   logic filter_acc;
   logic load_acc;

   assign filter_acc = req_valid && !req_stall && (req_opcode == fireq_pkg::OP_FILTER);
   assign load_acc   = req_valid && !req_stall && (req_opcode == fireq_pkg::OP_LOAD);

   `FIREQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sample_out), "stalled response changed or dropped")

   `FIREQ_ASSERT_NEXT(a_filter_busy, clock, reset, filter_acc, req_stall,
      "filter transaction did not occupy the datapath")

   `FIREQ_ASSERT_NEXT(a_load_single, clock, reset, load_acc, !req_stall,
      "coefficient load stalled the request channel")

   `FIREQ_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall),
      "response appeared without a filter transaction in progress")

endmodule

bind fir_equalizer_filter fireq_checker u_fireq_checker (.*);

// File: test/fir_equalizer_filter_tb.sv
// Self-checking testbench for fir_equalizer_filter: directed table, then random traffic,
// each filtered sample checked against a bit-true model of the FIR datapath or a fixed table value.
// Depends on fireq_pkg and the fir_equalizer_filter RTL.
module fir_equalizer_filter_tb;

   localparam int HALF_SPAN    = fireq_pkg::HALF_SPAN_DEFAULT;
   localparam int TAPS         = 2 * HALF_SPAN + 1;
   localparam int CLK_PERIOD   = 12;
   localparam int RANDOM_ITEMS = 600;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 2 * TAPS + 10;

   typedef logic signed [fireq_pkg::SAMPLE_W-1:0]  sample_type;
   typedef logic signed [fireq_pkg::COEF_W-1:0]    coef_type;
   typedef logic [fireq_pkg::COEF_INDEX_W-1:0]     tap_index_type;

   typedef struct {
      logic          op;
      sample_type    sample;
      tap_index_type index;
      coef_type      coef;
      bit            fixed;
      sample_type    want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid;
   logic          req_stall;
   logic          req_opcode;
   sample_type    req_sample_in;
   tap_index_type req_coef_index;
   coef_type      req_coef_value;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   sample_type    rsp_sample_out;

   // model state: delay line and coefficient store
   sample_type delay_line [TAPS];
   coef_type   tap_coef [TAPS];
   sample_type pending_samples [$];

   stim_row_type directed_rows [$];
   bit           row_fixed;
   sample_type   row_want;
   int           req_idle_pct = 24;
   int           rsp_stall_pct = 24;
   int           error_count = 0;

   fir_equalizer_filter #(
      .HALF_SPAN(HALF_SPAN)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      error_count++;
   endtask

   function automatic void clear_filter_state();
      for (int j = 0; j < TAPS; j++) begin
         delay_line[j] = '0;
         tap_coef[j] = '0;
      end
   endfunction

   function automatic void store_coef(input tap_index_type index, input coef_type value);
      // drop out-of-range taps
      if (index < TAPS) tap_coef[index] = value;
   endfunction

   // Sum of products over all taps, round half up, saturate, then shift the line.
   function automatic sample_type filter_sample(input sample_type sample);
      longint acc;
      longint q;
      acc = 0;
      delay_line[0] = sample;
      for (int j = 0; j < TAPS; j++)
         acc += longint'(delay_line[j]) * longint'(tap_coef[j]);
      q = (acc + 64'sd16384) >>> 15;
      if (q > fireq_pkg::SAT_MAX) q = fireq_pkg::SAT_MAX;
      if (q < fireq_pkg::SAT_MIN) q = fireq_pkg::SAT_MIN;
      for (int j = TAPS - 2; j >= 0; j--)
         delay_line[j + 1] = delay_line[j];
      return sample_type'(q);
   endfunction

   function automatic stim_row_type filter_row(input int sample, input bit fixed,
                                               input int want);
      stim_row_type r;
      r.op     = fireq_pkg::OP_FILTER;
      r.sample = sample_type'(sample);
      r.index  = tap_index_type'($urandom);
      r.coef   = coef_type'($urandom);
      r.fixed  = fixed;
      r.want   = sample_type'(want);
      return r;
   endfunction

   function automatic stim_row_type load_row(input int index, input int coef);
      stim_row_type r;
      r.op     = fireq_pkg::OP_LOAD;
      r.sample = sample_type'($urandom);
      r.index  = tap_index_type'(index);
      r.coef   = coef_type'(coef);
      r.fixed  = 1'b0;
      r.want   = '0;
      return r;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type r;
      int           sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
         r = load_row(0, 0);
         r.index = ($urandom_range(0, 9) == 0) ? tap_index_type'($urandom_range(TAPS, 63))
                                               : tap_index_type'($urandom_range(0, TAPS - 1));
         case ($urandom_range(0, 5)) inside
            0: r.coef = coef_type'(131071);
            1: r.coef = coef_type'(-131072);
            [2:3]: r.coef = coef_type'($urandom);
            default: r.coef = coef_type'(int'($urandom_range(0, 8191)) - 4096);
         endcase
      end else begin
         r = filter_row(0, 1'b0, 0);
         case ($urandom_range(0, 9))
            0: r.sample = sample_type'(32767);
            1: r.sample = sample_type'(-32768);
            2: r.sample = '0;
            default: r.sample = sample_type'($urandom);
         endcase
      end
      return r;
   endfunction

   // Entered and left at a falling edge; holds the transaction until accepted.
   task automatic send_item(input stim_row_type r);
      while (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_opcode <= 1'($urandom);
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.op;
      req_sample_in  <= r.sample;
      req_coef_index <= r.index;
      req_coef_value <= r.coef;
      row_fixed      <= r.fixed;
      row_want       <= r.want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      if (pending_samples.size() != 0) begin
         req_valid <= 1'b0;
         while (pending_samples.size() != 0) @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin : scoreboard
      sample_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected sample_out %0d", rsp_sample_out));
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample_out !== want)
                  report_mismatch($sformatf("sample_out got %0d want %0d",
                                            rsp_sample_out, want));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_opcode == fireq_pkg::OP_LOAD) begin
               store_coef(req_coef_index, req_coef_value);
            end else begin
               want = filter_sample(req_sample_in);
               if (row_fixed) want = row_want;
               pending_samples.push_back(want);
            end
         end
      end
   end

   initial begin
      req_valid      = 1'b0;
      req_opcode     = fireq_pkg::OP_FILTER;
      req_sample_in  = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      row_fixed      = 1'b0;
      row_want       = '0;
      clear_filter_state();

      // after reset every tap reads zero
      directed_rows.push_back(filter_row(32767, 1'b1, 0));
      directed_rows.push_back(filter_row(-32768, 1'b1, 0));
      directed_rows.push_back(load_row(TAPS, 5));
      directed_rows.push_back(load_row(63, -1));
      directed_rows.push_back(filter_row(1, 1'b1, 0));
      // unity tap at the head of the line
      directed_rows.push_back(load_row(0, 32768));
      directed_rows.push_back(filter_row(32767, 1'b1, 32767));
      directed_rows.push_back(filter_row(-32768, 1'b1, -32768));
      // most negative coefficient: saturate both ways
      directed_rows.push_back(load_row(0, -131072));
      directed_rows.push_back(filter_row(-32768, 1'b1, 32767));
      directed_rows.push_back(filter_row(32767, 1'b1, -32768));
      // smallest coefficient: rounding ties go up
      directed_rows.push_back(load_row(0, 1));
      directed_rows.push_back(filter_row(16384, 1'b1, 1));
      directed_rows.push_back(filter_row(-16384, 1'b1, 0));
      directed_rows.push_back(filter_row(16383, 1'b1, 0));
      directed_rows.push_back(filter_row(-16385, 1'b1, -1));
      directed_rows.push_back(load_row(0, 131071));
      directed_rows.push_back(load_row(TAPS - 1, -131072));
      directed_rows.push_back(load_row(HALF_SPAN, 12345));
      directed_rows.push_back(filter_row(0, 1'b0, 0));
      directed_rows.push_back(filter_row(21845, 1'b0, 0));
      directed_rows.push_back(filter_row(-21846, 1'b0, 0));
      directed_rows.push_back(filter_row(32767, 1'b0, 0));
      directed_rows.push_back(filter_row(-32768, 1'b0, 0));

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 200) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         if (i == 350) begin
            req_idle_pct  = 24;
            rsp_stall_pct = 24;
         end
         // hold off the sender until the pipe drains
         if (i == 300 || i == 480) wait_for_results();
         send_item(random_row());
      end

      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("fir_equalizer_filter_tb: clean");
      end else begin
         if (pending_samples.size() != 0)
            report_mismatch($sformatf("%0d samples never came out", pending_samples.size()));
         $display("fir_equalizer_filter_tb: errors");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("fir_equalizer_filter_tb: errors");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/fireq_pkg.sv
rtl/fir_equalizer_filter.sv
rtl/fireq_checker.sv
test/fir_equalizer_filter_tb.sv
